FILE: src/lorgu_pkg.sv
// Shared types and codes for the log-odds ray grid update block.
`timescale 1ns / 1ps

package lorgu_pkg;

  // Operation codes; code 3 is handled as a read
  localparam logic [1:0] OP_RAY  = 2'd0;
  localparam logic [1:0] OP_MARK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Cell classes
  localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLASS_FREE    = 2'd1;
  localparam logic [1:0] CLASS_LETHAL  = 2'd2;
  localparam logic [1:0] CLASS_OUTSIDE = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_INCREMENT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_INCREMENT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCUPY_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_THRESHOLD   = 3'd4;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 10;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         cell_class;
    logic               covered;
    logic [COUNT_W-1:0] cells_updated;
  } out_item_t;

  typedef struct packed {
    logic [14:0]        hit_increment;
    logic signed [15:0] miss_increment;
    logic [14:0]        clamp_limit;
    logic [14:0]        occupy_threshold;
    logic signed [15:0] free_threshold;
  } cfg_t;

  // One grid cell as stored in the cell memory
  typedef struct packed {
    logic               covered;
    logic signed [15:0] log_odds;
  } cell_t;

  // Update applied by the cell unit
  typedef enum logic [1:0] {
    CELL_NONE,
    CELL_MISS,
    CELL_HIT,
    CELL_MARK
  } cell_op_e;

endpackage

FILE: src/lorgu_cell_alu.sv
// Saturating log-odds update, covered marking and classification of one cell.
`timescale 1ns / 1ps

module lorgu_cell_alu (
  input  lorgu_pkg::cell_op_e mode_i,
  input  lorgu_pkg::cfg_t     cfg_i,
  input  lorgu_pkg::cell_t    old_i,
  output lorgu_pkg::cell_t    new_o,
  output logic                changed_o,
  output logic [1:0]          cell_class_o
);
  import lorgu_pkg::*;

  logic signed [15:0] half_miss;
  logic signed [16:0] delta;
  logic signed [16:0] sum;
  logic signed [16:0] lim;
  logic signed [16:0] sat;
  logic               apply;
  logic signed [15:0] val;
  logic               cov_set;

  assign half_miss = cfg_i.miss_increment >>> 1;

  always_comb begin
    unique case (mode_i)
      CELL_MISS: delta = {cfg_i.miss_increment[15], cfg_i.miss_increment};
      CELL_HIT:  delta = {2'b00, cfg_i.hit_increment};
      CELL_MARK: delta = {half_miss[15], half_miss};
      default:   delta = '0;
    endcase
  end

  assign sum = {old_i.log_odds[15], old_i.log_odds} + delta;
  assign lim = {2'b00, cfg_i.clamp_limit};

  always_comb begin
    if (sum > lim) begin
      sat = lim;
    end else if (sum < -lim) begin
      sat = -lim;
    end else begin
      sat = sum;
    end
  end

  // Mark only adds to a cell that is still unknown
  assign apply = (mode_i == CELL_MISS) || (mode_i == CELL_HIT) ||
                 ((mode_i == CELL_MARK) && (old_i.log_odds == 16'sd0));
  assign val   = apply ? sat[15:0] : old_i.log_odds;

  assign cov_set = (mode_i == CELL_MARK) && (val != 16'sd0) &&
                   (val <= cfg_i.free_threshold) && !old_i.covered;

  assign new_o.log_odds = val;
  assign new_o.covered  = old_i.covered | cov_set;
  assign changed_o      = (val != old_i.log_odds) || cov_set;

  always_comb begin
    if (val >= $signed({1'b0, cfg_i.occupy_threshold})) begin
      cell_class_o = CLASS_LETHAL;
    end else if (val == 16'sd0) begin
      cell_class_o = CLASS_UNKNOWN;
    end else begin
      cell_class_o = CLASS_FREE;
    end
  end

endmodule

FILE: src/log_odds_ray_grid_update.sv
// Top level of the log-odds occupancy grid with Bresenham ray updates.
`timescale 1ns / 1ps

// Occupancy grid of GRID_WIDTH x GRID_HEIGHT cells, each a signed Q8.8
// log-odds value plus a covered bit, held in one single-port memory.
// After reset the block sweeps the memory to zero, one cell per cycle;
// in_stall_o stays high during the sweep (configuration writes are taken
// at any time). Every item gives exactly one result. Steps per item: take
// the item, line geometry, target address; then for a ray a read and a
// write back per walked cell (max(|dx|,|dy|) cells before the target) and
// one more check to see the walk end; then a read of the target cell and,
// for a hit or mark, its write back, and last the result is posted. An
// off-grid target skips its target cell steps. The pace is set by the
// read-modify-write of the cell memory: the registered read and the write
// back each take a turn of the one port. A finished result waits in an
// output register, and the next item is taken meanwhile.
module log_odds_ray_grid_update #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lorgu_pkg::in_item_t                   in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lorgu_pkg::out_item_t                  out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [lorgu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lorgu_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import lorgu_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int DW    = (XW > YW) ? XW : YW;

  localparam logic [AW-1:0] LAST_IDX  = AW'(CELLS - 1);
  localparam logic [AW-1:0] STEP_COL  = AW'(1);
  localparam logic [AW-1:0] STEP_ROW  = AW'(GRID_WIDTH);
  localparam logic [XW-1:0] MAX_X     = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] MAX_Y     = YW'(GRID_HEIGHT - 1);
  localparam logic signed [15:0] MAX_X_S = 16'(GRID_WIDTH - 1);
  localparam logic signed [15:0] MAX_Y_S = 16'(GRID_HEIGHT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,  // zero the cell memory after reset
    ST_IDLE,   // wait for an item
    ST_ORG,    // ray geometry and origin address
    ST_TGT,    // target address
    ST_WRD,    // walk: check end, read cell
    ST_WMOD,   // walk: add miss, write back, step the line
    ST_TRD,    // read the addressed cell
    ST_TMOD,   // hit or mark, classify
    ST_DONE    // post the result
  } state_e;

  // ---------------------------------------------------------------- registers
  state_e             state_q;
  cfg_t               cfg_q;
  in_item_t           item_q;
  logic [AW-1:0]      idx_q;     // walk address, also the clearing counter
  logic [AW-1:0]      tidx_q;    // address of the (clamped) target cell
  logic               org_in_q;
  logic               tgt_in_q;
  logic               xmaj_q;
  logic               sx_q;
  logic               sy_q;
  logic [DW-1:0]      den_q;
  logic [DW-1:0]      num_q;
  logic [DW-1:0]      add_q;
  logic [DW-1:0]      pix_q;
  logic [DW-1:0]      cnt_q;
  logic [COUNT_W-1:0] chg_q;
  logic [1:0]         cls_q;
  logic               cov_q;
  logic               out_valid_q;
  out_item_t          out_q;

  // ------------------------------------------------------------ cell memory
  cell_t         mem [CELLS];
  cell_t         rd_q;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic          mem_re;
  cell_t         mem_wdata;

  // -------------------------------------------------- coordinate decoding
  logic          ox_in, oy_in, org_in;
  logic          tx_in, ty_in, tgt_in;
  logic [XW-1:0] x1;
  logic [YW-1:0] y1;
  logic [XW-1:0] ox_c;
  logic [YW-1:0] oy_c;

  assign ox_in  = !item_q.start_x[15] && (item_q.start_x <= MAX_X_S);
  assign oy_in  = !item_q.start_y[15] && (item_q.start_y <= MAX_Y_S);
  assign tx_in  = !item_q.target_x[15] && (item_q.target_x <= MAX_X_S);
  assign ty_in  = !item_q.target_y[15] && (item_q.target_y <= MAX_Y_S);
  assign org_in = ox_in && oy_in;
  assign tgt_in = tx_in && ty_in;
  assign ox_c   = item_q.start_x[XW-1:0];
  assign oy_c   = item_q.start_y[YW-1:0];

  // Clamp the target to the grid border
  always_comb begin
    if (item_q.target_x[15]) begin
      x1 = '0;
    end else if (!tx_in) begin
      x1 = MAX_X;
    end else begin
      x1 = item_q.target_x[XW-1:0];
    end
    if (item_q.target_y[15]) begin
      y1 = '0;
    end else if (!ty_in) begin
      y1 = MAX_Y;
    end else begin
      y1 = item_q.target_y[YW-1:0];
    end
  end

  // ----------------------------------------------------- line geometry
  logic signed [XW:0] dxs;
  logic signed [YW:0] dys;
  logic [XW-1:0]      dx;
  logic [YW-1:0]      dy;
  logic               sx, sy, xmaj;
  logic [DW-1:0]      dx_w, dy_w;

  assign dxs  = $signed({1'b0, x1}) - $signed({1'b0, ox_c});
  assign dys  = $signed({1'b0, y1}) - $signed({1'b0, oy_c});
  assign sx   = !dxs[XW];
  assign sy   = !dys[YW];
  assign dx   = sx ? dxs[XW-1:0] : XW'(-dxs);
  assign dy   = sy ? dys[YW-1:0] : YW'(-dys);
  assign dx_w = DW'(dx);
  assign dy_w = DW'(dy);
  assign xmaj = dx_w >= dy_w;

  // Shared address multiplier: origin in ST_ORG, clamped target in ST_TGT
  logic [XW-1:0] mul_x;
  logic [YW-1:0] mul_y;
  logic [AW-1:0] mul_idx;

  assign mul_x   = (state_q == ST_TGT) ? x1 : ox_c;
  assign mul_y   = (state_q == ST_TGT) ? y1 : oy_c;
  assign mul_idx = AW'(mul_y) * STEP_ROW + AW'(mul_x);

  // ------------------------------------------------------ Bresenham step
  logic [DW:0]   nsum;
  logic          step_minor;
  logic [DW-1:0] num_next;
  logic [AW-1:0] major_delta;
  logic [AW-1:0] minor_delta;
  logic [AW-1:0] idx_next;
  logic          walk_end;

  assign nsum        = {1'b0, num_q} + {1'b0, add_q};
  assign step_minor  = nsum >= {1'b0, den_q};
  assign num_next    = step_minor ? DW'(nsum - {1'b0, den_q}) : nsum[DW-1:0];
  assign major_delta = xmaj_q ? (sx_q ? STEP_COL : -STEP_COL)
                              : (sy_q ? STEP_ROW : -STEP_ROW);
  assign minor_delta = xmaj_q ? (sy_q ? STEP_ROW : -STEP_ROW)
                              : (sx_q ? STEP_COL : -STEP_COL);
  assign idx_next    = idx_q + major_delta + (step_minor ? minor_delta : '0);
  assign walk_end    = (cnt_q == pix_q) || (idx_q == tidx_q);

  // ------------------------------------------------------------ cell unit
  cell_op_e   alu_mode;
  cell_op_e   tgt_mode;
  cell_t      alu_new;
  logic       alu_changed;
  logic [1:0] alu_class;

  always_comb begin
    if ((item_q.operation == OP_RAY) && org_in_q && tgt_in_q) begin
      tgt_mode = CELL_HIT;
    end else if (item_q.operation == OP_MARK) begin
      tgt_mode = CELL_MARK;
    end else begin
      tgt_mode = CELL_NONE;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_WMOD: alu_mode = CELL_MISS;
      ST_TMOD: alu_mode = tgt_mode;
      default: alu_mode = CELL_NONE;
    endcase
  end

  lorgu_cell_alu u_alu (
    .mode_i       (alu_mode),
    .cfg_i        (cfg_q),
    .old_i        (rd_q),
    .new_o        (alu_new),
    .changed_o    (alu_changed),
    .cell_class_o (alu_class)
  );

  // -------------------------------------------------- memory port control
  assign mem_addr  = ((state_q == ST_TRD) || (state_q == ST_TMOD)) ? tidx_q : idx_q;
  assign mem_re    = (state_q == ST_WRD) || (state_q == ST_TRD);
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WMOD) ||
                     ((state_q == ST_TMOD) && (tgt_mode != CELL_NONE));
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : alu_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Saturating change count
  logic [COUNT_W-1:0] chg_add;
  assign chg_add = ((chg_q != '1) && alu_changed) ? chg_q + COUNT_W'(1) : chg_q;

  // ---------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      cfg_q.hit_increment    <= 15'd218;
      cfg_q.miss_increment   <= -16'sd102;
      cfg_q.clamp_limit      <= 15'd896;
      cfg_q.occupy_threshold <= 15'd218;
      cfg_q.free_threshold   <= -16'sd102;
    end else begin
      // Drop the posted result once taken, unless ST_DONE posts the next one
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_HIT_INCREMENT:    cfg_q.hit_increment    <= cfg_data_i[14:0];
          CFG_MISS_INCREMENT:   cfg_q.miss_increment   <= $signed(cfg_data_i);
          CFG_CLAMP_LIMIT:      cfg_q.clamp_limit      <= cfg_data_i[14:0];
          CFG_OCCUPY_THRESHOLD: cfg_q.occupy_threshold <= cfg_data_i[14:0];
          CFG_FREE_THRESHOLD:   cfg_q.free_threshold   <= $signed(cfg_data_i);
          default: ;
        endcase
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (idx_q == LAST_IDX) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end

        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_ORG;
          end
        end

        ST_ORG: begin
          org_in_q <= org_in;
          tgt_in_q <= tgt_in;
          idx_q    <= mul_idx;
          xmaj_q   <= xmaj;
          sx_q     <= sx;
          sy_q     <= sy;
          den_q    <= xmaj ? dx_w : dy_w;
          num_q    <= (xmaj ? dx_w : dy_w) >> 1;
          add_q    <= xmaj ? dy_w : dx_w;
          pix_q    <= xmaj ? dx_w : dy_w;
          cnt_q    <= '0;
          chg_q    <= '0;
          state_q  <= ST_TGT;
        end

        ST_TGT: begin
          tidx_q <= mul_idx;
          if ((item_q.operation == OP_RAY) && org_in_q) begin
            state_q <= ST_WRD;
          end else if (tgt_in_q) begin
            state_q <= ST_TRD;
          end else begin
            cls_q   <= CLASS_OUTSIDE;
            cov_q   <= 1'b0;
            state_q <= ST_DONE;
          end
        end

        ST_WRD: begin
          if (!walk_end) begin
            state_q <= ST_WMOD;
          end else if (tgt_in_q) begin
            state_q <= ST_TRD;
          end else begin
            cls_q   <= CLASS_OUTSIDE;
            cov_q   <= 1'b0;
            state_q <= ST_DONE;
          end
        end

        ST_WMOD: begin
          // Advance one cell along the line
          chg_q   <= chg_add;
          num_q   <= num_next;
          idx_q   <= idx_next;
          cnt_q   <= cnt_q + DW'(1);
          state_q <= ST_WRD;
        end

        ST_TRD: begin
          state_q <= ST_TMOD;
        end

        ST_TMOD: begin
          chg_q   <= chg_add;
          cls_q   <= alu_class;
          cov_q   <= alu_new.covered;
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_q.cell_class    <= cls_q;
            out_q.covered       <= cov_q;
            out_q.cells_updated <= chg_q;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: dv/grid_update_checker.sv
// Checker for the log-odds ray grid update block: grid prediction and result comparison.
`timescale 1ns / 1ps

module grid_update_checker #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  lorgu_pkg::in_item_t              in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  lorgu_pkg::out_item_t             out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [lorgu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lorgu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      reports_due_o
);
  import lorgu_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

  logic signed [15:0] odds_mem    [CELLS];
  bit                 covered_mem [CELLS];
  cfg_t               shadow_cfg;
  out_item_t          reports_due [$];
  out_item_t          oldest;
  int unsigned        mismatches = 0;
  int unsigned        results_seen = 0;

  initial begin
    foreach (odds_mem[i]) begin
      odds_mem[i]    = '0;
      covered_mem[i] = 1'b0;
    end
  end

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < GRID_WIDTH && y < GRID_HEIGHT;
  endfunction

  function automatic int clip_coord(int v, int size);
    if (v < 0) return 0;
    if (v > size - 1) return size - 1;
    return v;
  endfunction

  // Saturating add to one cell; returns 1 when the value moved.
  function automatic int unsigned bump_cell(int x, int y, int delta);
    int slot;
    int prior;
    int sum;
    int bound;
    slot  = y * GRID_WIDTH + x;
    prior = odds_mem[slot];
    bound = int'(shadow_cfg.clamp_limit);
    sum   = prior + delta;
    if (sum > bound) sum = bound;
    if (sum < -bound) sum = -bound;
    odds_mem[slot] = 16'(sum);
    return (sum != prior) ? 1 : 0;
  endfunction

  function automatic int unsigned walk_ray(int ox, int oy, int tx, int ty);
    int unsigned touched;
    int ex, ey, dx, dy, sx, sy, x, y, acc, span, rise, i;
    bit x_major;
    touched = 0;
    if (!on_grid(ox, oy)) return 0;
    ex = clip_coord(tx, GRID_WIDTH);
    ey = clip_coord(ty, GRID_HEIGHT);
    dx = (ex >= ox) ? ex - ox : ox - ex;
    dy = (ey >= oy) ? ey - oy : oy - ey;
    sx = (ex >= ox) ? 1 : -1;
    sy = (ey >= oy) ? 1 : -1;
    x_major = (dx >= dy);
    span = x_major ? dx : dy;
    rise = x_major ? dy : dx;
    acc  = span / 2;
    x = ox;
    y = oy;
    for (i = 0; i < span; i++) begin
      if (x == ex && y == ey) break;
      if (on_grid(x, y)) touched += bump_cell(x, y, int'(shadow_cfg.miss_increment));
      acc += rise;
      if (acc >= span) begin
        acc -= span;
        if (x_major) y += sy;
        else x += sx;
      end
      if (x_major) x += sx;
      else y += sy;
    end
    // a clipped target gets the miss walk but no hit
    if (on_grid(tx, ty)) touched += bump_cell(tx, ty, int'(shadow_cfg.hit_increment));
    return touched;
  endfunction

  function automatic int unsigned mark_cell(int tx, int ty);
    int unsigned touched;
    int slot;
    int half;
    int v;
    touched = 0;
    if (!on_grid(tx, ty)) return 0;
    slot = ty * GRID_WIDTH + tx;
    // half miss rounds toward minus infinity
    half = int'(shadow_cfg.miss_increment) >>> 1;
    if (odds_mem[slot] == 0) touched = bump_cell(tx, ty, half);
    v = odds_mem[slot];
    if (v != 0 && v <= int'(shadow_cfg.free_threshold) && !covered_mem[slot]) begin
      covered_mem[slot] = 1'b1;
      touched = 1;
    end
    return touched;
  endfunction

  function automatic out_item_t apply_item(in_item_t item);
    out_item_t report;
    int unsigned touched;
    int tx, ty, slot, v;
    tx = item.target_x;
    ty = item.target_y;
    touched = 0;
    case (item.operation)
      OP_RAY:  touched = walk_ray(item.start_x, item.start_y, tx, ty);
      OP_MARK: touched = mark_cell(tx, ty);
      default: ;
    endcase
    if (on_grid(tx, ty)) begin
      slot = ty * GRID_WIDTH + tx;
      v = odds_mem[slot];
      if (v >= int'(shadow_cfg.occupy_threshold)) report.cell_class = CLASS_LETHAL;
      else if (v == 0) report.cell_class = CLASS_UNKNOWN;
      else report.cell_class = CLASS_FREE;
      report.covered = covered_mem[slot];
    end else begin
      report.cell_class = CLASS_OUTSIDE;
      report.covered    = 1'b0;
    end
    report.cells_updated = (touched > 1023) ? 10'd1023 : COUNT_W'(touched);
    return report;
  endfunction

  task automatic report_mismatch(string detail);
    if (mismatches < 60) $display("%0t ns grid check: %s", $time, detail);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg.hit_increment    = 15'd218;
      shadow_cfg.miss_increment   = -16'sd102;
      shadow_cfg.clamp_limit      = 15'd896;
      shadow_cfg.occupy_threshold = 15'd218;
      shadow_cfg.free_threshold   = -16'sd102;
      reports_due.delete();
      reports_due_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_HIT_INCREMENT:    shadow_cfg.hit_increment    = cfg_data_i[14:0];
          CFG_MISS_INCREMENT:   shadow_cfg.miss_increment   = cfg_data_i;
          CFG_CLAMP_LIMIT:      shadow_cfg.clamp_limit      = cfg_data_i[14:0];
          CFG_OCCUPY_THRESHOLD: shadow_cfg.occupy_threshold = cfg_data_i[14:0];
          CFG_FREE_THRESHOLD:   shadow_cfg.free_threshold   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        reports_due.insert(reports_due.size(), apply_item(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          oldest = reports_due.pop_front();
          if (out_data_i.cell_class !== oldest.cell_class)
            report_mismatch($sformatf("result %0d: cell_class %0d, expected %0d",
                                      results_seen, out_data_i.cell_class, oldest.cell_class));
          if (out_data_i.covered !== oldest.covered)
            report_mismatch($sformatf("result %0d: covered %0d, expected %0d",
                                      results_seen, out_data_i.covered, oldest.covered));
          if (out_data_i.cells_updated !== oldest.cells_updated)
            report_mismatch($sformatf("result %0d: cells_updated %0d, expected %0d",
                                      results_seen, out_data_i.cells_updated,
                                      oldest.cells_updated));
        end
      end
      reports_due_o    <= reports_due.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the grid update testbench: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module testbench;
  import lorgu_pkg::*;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int CLK_PERIOD  = 20;

  // Settle after each phase before touching registers; every item gives one
  // result, so a handful of cycles covers the result register.
  localparam int SETTLE_CYCLES = 8;
  // Tail after the last result: longer than a full-width ray.
  localparam int TAIL_CYCLES = 600;
  // Watchdog: allows about four times the clearing sweep plus every item as a
  // full-width ray with the longest gaps and stalls.
  localparam longint LIMIT_NS = 64'd50_000_000;

  // Operation code 3 has no name in the package; the block treats it as a read.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  localparam int PHASES = 6;
  int unsigned phase_items [PHASES] = '{180, 150, 120, 150, 180, 150};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           mismatch_count;
  int unsigned           reports_due;

  // Set for stretches of items where neither side idles.
  bit steady_flow = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  log_odds_ray_grid_update #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  grid_update_checker #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_item),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_item),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatch_count),
    .reports_due_o   (reports_due)
  );

  function automatic in_item_t make_item(logic [1:0] op, int ox, int oy, int tx, int ty);
    in_item_t it;
    it.operation = op;
    it.start_x   = 16'(ox);
    it.start_y   = 16'(oy);
    it.target_x  = 16'(tx);
    it.target_y  = 16'(ty);
    return it;
  endfunction

  function automatic cfg_t settings(int hit, int miss, int clamp, int occupy, int free);
    cfg_t s;
    s.hit_increment    = 15'(hit);
    s.miss_increment   = 16'(miss);
    s.clamp_limit      = 15'(clamp);
    s.occupy_threshold = 15'(occupy);
    s.free_threshold   = 16'(free);
    return s;
  endfunction

  // Pick one coordinate: mostly a dense corner so cells get hit again and
  // again, then anywhere on the grid, the border, just off the grid, and
  // now and then any 16-bit value.
  function automatic logic [15:0] pick_coord(int size);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'($urandom_range(0, 23));
    if (roll < 75) return 16'($urandom_range(0, size - 1));
    if (roll < 85) return $urandom_range(0, 1) ? 16'(size - 1) : 16'(0);
    if (roll < 93) begin
      if ($urandom_range(0, 1)) return 16'(-int'($urandom_range(1, 4)));
      return 16'(size + int'($urandom_range(0, 3)));
    end
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 48) it.operation = OP_RAY;
    else if (roll < 68) it.operation = OP_MARK;
    else if (roll < 93) it.operation = OP_READ;
    else it.operation = OP_SPARE;
    it.start_x  = pick_coord(GRID_WIDTH);
    it.start_y  = pick_coord(GRID_HEIGHT);
    it.target_x = pick_coord(GRID_WIDTH);
    it.target_y = pick_coord(GRID_HEIGHT);
    return it;
  endfunction

  // Present one register write and hold it until taken. Leave valid high so
  // back-to-back writes never drop and raise it in the same step.
  task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(cfg_t s);
    put_register(CFG_HIT_INCREMENT,    CFG_DATA_W'(s.hit_increment));
    put_register(CFG_MISS_INCREMENT,   s.miss_increment);
    put_register(CFG_CLAMP_LIMIT,      CFG_DATA_W'(s.clamp_limit));
    put_register(CFG_OCCUPY_THRESHOLD, CFG_DATA_W'(s.occupy_threshold));
    put_register(CFG_FREE_THRESHOLD,   s.free_threshold);
    cfg_valid <= 1'b0;
  endtask

  // Idle for a random gap, then present the item and hold it while stalled.
  // With no gap, valid simply stays high into the next item.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: stall for a random number of cycles, then take one item.
  initial begin : result_pacing
    int unsigned hold;
    @(posedge clk);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t     plan [PHASES];
    in_item_t directed [$];
    int unsigned p;
    int unsigned n;

    plan[0] = settings(218, -102, 896, 218, -102);
    plan[1] = settings(32767, -32768, 32767, 32767, -32768);
    plan[2] = settings(0, 0, 0, 0, 0);
    plan[3] = settings(1, -1, 3, 1, -1);
    plan[4] = settings($urandom_range(1, 600), -int'($urandom_range(0, 600)),
                       $urandom_range(100, 2000), $urandom_range(0, 1500),
                       -int'($urandom_range(0, 600)));
    plan[5] = plan[0];

    // Directed items, run on the fresh grid with the reset values:
    // reads of corners, off-grid cells and the spare code first,
    directed = {directed, make_item(OP_READ, 0, 0, 0, 0)};
    directed = {directed, make_item(OP_READ, 0, 0, 255, 255)};
    directed = {directed, make_item(OP_READ, 0, 0, -1, 0)};
    directed = {directed, make_item(OP_READ, 0, 0, 0, 256)};
    directed = {directed, make_item(OP_SPARE, 0, 0, 10, 10)};
    directed = {directed, make_item(OP_READ, 0, 0, -32768, 32767)};
    // a mark on a zero cell, again on the now nonzero cell, and off the grid,
    directed = {directed, make_item(OP_MARK, 0, 0, 5, 5)};
    directed = {directed, make_item(OP_MARK, 0, 0, 5, 5)};
    directed = {directed, make_item(OP_MARK, 0, 0, 256, 256)};
    // full-width rays, a ray onto its own origin, an off-grid origin,
    // off-grid targets that get clipped for the walk, and a steep ray,
    directed = {directed, make_item(OP_RAY, 0, 0, 255, 0)};
    directed = {directed, make_item(OP_RAY, 255, 255, 0, 0)};
    directed = {directed, make_item(OP_RAY, 20, 20, 20, 20)};
    directed = {directed, make_item(OP_RAY, -1, 5, 10, 10)};
    directed = {directed, make_item(OP_RAY, 32767, -32768, 0, 0)};
    directed = {directed, make_item(OP_RAY, 100, 100, 300, -50)};
    directed = {directed, make_item(OP_RAY, 10, 10, -32768, 32767)};
    directed = {directed, make_item(OP_RAY, 30, 0, 40, 255)};
    // then the same short ray until the target saturates at the clamp,
    repeat (5) directed = {directed, make_item(OP_RAY, 0, 1, 3, 1)};
    // a mark that sets covered on a missed cell, and the lethal target.
    directed = {directed, make_item(OP_MARK, 0, 0, 1, 1)};
    directed = {directed, make_item(OP_READ, 0, 0, 3, 1)};
    directed = {directed, make_item(OP_MARK, 0, 0, 3, 1)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      if (p == 1) put_register(CFG_UNMAPPED, '1);
      load_settings(plan[p]);
      if (p == 0) begin
        foreach (directed[i]) send_item(directed[i]);
      end
      for (n = 0; n < phase_items[p]; n++) begin
        if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
        send_item(random_item());
      end
      // Drop valid and drain every outstanding result before the next phase.
      in_valid <= 1'b0;
      steady_flow = 1'b0;
      @(posedge clk);
      while (reports_due != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: files.f
src/lorgu_pkg.sv
src/lorgu_cell_alu.sv
src/log_odds_ray_grid_update.sv
dv/grid_update_checker.sv
dv/testbench.sv
